// File: rtl/days_to_calendar_date_assert.svh
// assertion macros used by the checker file
`ifndef DAYS_TO_CALENDAR_DATE_ASSERT_SVH
`define DAYS_TO_CALENDAR_DATE_ASSERT_SVH

// clocked property, quiet while reset is high
`define D2CD_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("days_to_calendar_date port check failed");

// property that must hold whenever a result is offered
`define D2CD_ASSERT_VALID(lbl, expr) \
  `D2CD_ASSERT(lbl, out_valid |-> (expr))

`endif

// File: rtl/d2cd_pkg.sv
`default_nettype none

package d2cd_pkg;

  localparam logic [11:0] EPOCH_YEAR        = 12'd1980;
  // only century year in 1980..2159 that is not a leap year
  localparam logic [11:0] CENTURY_NON_LEAP  = 12'd2100;
  localparam logic [8:0]  YEAR_LEN_NORMAL   = 9'd365;
  localparam logic [8:0]  YEAR_LEN_LEAP     = 9'd366;
  localparam logic [3:0]  LAST_MONTH_IDX    = 4'd11;
  localparam logic [3:0]  WEEK_LEN          = 4'd7;

  // result of the shared compare/subtract unit
  typedef struct packed {
    logic        gt;
    logic [15:0] diff;
  } d2cd_sub_t;

  // leap rule, valid for the years this block can reach
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (y != CENTURY_NON_LEAP);
  endfunction

  function automatic logic [8:0] year_len(input logic leap);
    return leap ? YEAR_LEN_LEAP : YEAR_LEN_NORMAL;
  endfunction

  // month length table, index 0 is January
  function automatic logic [4:0] month_len(input logic [3:0] idx, input logic leap);
    logic [4:0] len;
    unique case (idx)
      4'd1:                     len = leap ? 5'd29 : 5'd28;
      4'd3, 4'd5, 4'd8, 4'd10:  len = 5'd30;
      default:                  len = 5'd31;
    endcase
    return len;
  endfunction

  // (count + 1) mod 7 by folding octal digits, since 8 mod 7 is 1
  function automatic logic [2:0] weekday_of(input logic [15:0] count);
    logic [16:0] v;
    logic [5:0]  s;
    logic [3:0]  f;
    logic [3:0]  r;
    v = {1'b0, count} + 17'd1;
    s = {3'b0, v[2:0]} + {3'b0, v[5:3]} + {3'b0, v[8:6]} + {3'b0, v[11:9]}
      + {3'b0, v[14:12]} + {4'b0, v[16:15]};
    f = {1'b0, s[5:3]} + {1'b0, s[2:0]};
    r = (f >= WEEK_LEN) ? (f - WEEK_LEN) : f;
    return r[2:0];
  endfunction

endpackage

`default_nettype wire

// File: rtl/d2cd_day_if.sv
`default_nettype none

interface d2cd_day_if;
  logic        valid;
  logic        ready;
  logic [15:0] day_count;

  modport source (output valid, output day_count, input ready);
  modport sink   (input valid, input day_count, output ready);
endinterface

`default_nettype wire

// File: rtl/d2cd_date_if.sv
`default_nettype none

interface d2cd_date_if;
  logic        valid;
  logic        ready;
  logic [11:0] year_number;
  logic [8:0]  day_in_year;
  logic [3:0]  month_number;
  logic [4:0]  day_in_month;
  logic [2:0]  weekday;

  modport source (
    output valid, output year_number, output day_in_year,
    output month_number, output day_in_month, output weekday, input ready
  );
  modport sink (
    input valid, input year_number, input day_in_year,
    input month_number, input day_in_month, input weekday, output ready
  );
endinterface

`default_nettype wire

// File: rtl/d2cd_sub.sv
`default_nettype none

module d2cd_sub
  import d2cd_pkg::*;
(
  input  wire logic [15:0] a,
  input  wire logic [8:0]  b,
  output d2cd_sub_t        res
);

  logic [16:0] wide;

  // a - b with borrow; gt means a is strictly above b
  assign wide     = {1'b0, a} - {8'b0, b};
  assign res.diff = wide[15:0];
  assign res.gt   = !wide[16] && (wide[15:0] != 16'd0);

endmodule

`default_nettype wire

// File: rtl/days_to_calendar_date.sv
// Day count to calendar date converter.
// Input channel days carries day_count, where 1 is January 1, 1980; the
// output channel date carries year, day of year, month, day of month and
// weekday (0 is Sunday). Both channels use a valid/ready transfer.
// One item is converted at a time. After an input transfer a sequencer
// drives a single compare/subtract unit: it takes away whole years one by
// one until a final compare finds the rest below a year, then months the
// same way; the output register loads in that final month step if it is
// free, else the sequencer waits in a hold state until it is. days.ready
// rises with date.valid, so the next item is taken once the result loads.
// days.ready is high only while the sequencer is idle.
// The output register holds a finished result until the receiver takes it;
// while the receiver stalls, the next conversion runs and then waits with
// its result until the register frees up.
// Reset (synchronous, rst) returns the sequencer to idle and drops
// date.valid; the block keeps no other state between items.
// A day_count of 0 gives 1980, day 0 of month 1, weekday 1.
`default_nettype none

module days_to_calendar_date
  import d2cd_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  d2cd_day_if.sink    days,
  d2cd_date_if.source date
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_YEAR  = 2'd1;
  localparam logic [1:0] ST_MONTH = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0]  state;
  logic [15:0] remain;
  logic [11:0] year;
  logic [8:0]  doy;
  logic [3:0]  month;
  logic [2:0]  wday;
  logic        leap;

  logic        out_valid;
  logic [11:0] out_year;
  logic [8:0]  out_doy;
  logic [3:0]  out_month;
  logic [4:0]  out_dom;
  logic [2:0]  out_wday;

  logic [8:0]  operand;
  d2cd_sub_t   step;
  logic        in_xfer;
  logic        out_free;
  logic        month_done;
  logic        load_out;

  // shared compare/subtract unit
  assign operand = (state == ST_YEAR) ? year_len(is_leap(year))
                                      : {4'b0, month_len(month, leap)};

  d2cd_sub u_sub (
    .a   (remain),
    .b   (operand),
    .res (step)
  );

  assign days.ready = (state == ST_IDLE);
  assign in_xfer    = days.valid && days.ready;
  assign out_free   = !out_valid || date.ready;
  assign month_done = (state == ST_MONTH) && !((month != LAST_MONTH_IDX) && step.gt);
  assign load_out   = (month_done || (state == ST_HOLD)) && out_free;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            state <= ST_YEAR;
          end
        end
        ST_YEAR: begin
          if (!step.gt) begin
            state <= ST_MONTH;
          end
        end
        ST_MONTH: begin
          if (month_done) begin
            state <= load_out ? ST_IDLE : ST_HOLD;
          end
        end
        ST_HOLD: begin
          if (load_out) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      remain <= days.day_count;
      year   <= EPOCH_YEAR;
      wday   <= weekday_of(days.day_count);
    end else if (state == ST_YEAR) begin
      if (step.gt) begin
        remain <= step.diff;
        year   <= year + 12'd1;
      end else begin
        doy   <= remain[8:0];
        leap  <= is_leap(year);
        month <= 4'd0;
      end
    end else if ((state == ST_MONTH) && !month_done) begin
      remain <= step.diff;
      month  <= month + 4'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (date.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_year  <= year;
      out_doy   <= doy;
      out_month <= month + 4'd1;
      out_dom   <= remain[4:0];
      out_wday  <= wday;
    end
  end

  assign date.valid        = out_valid;
  assign date.year_number  = out_year;
  assign date.day_in_year  = out_doy;
  assign date.month_number = out_month;
  assign date.day_in_month = out_dom;
  assign date.weekday      = out_wday;

endmodule

`default_nettype wire

// File: rtl/d2cd_check.sv
`default_nettype none
`include "days_to_calendar_date_assert.svh"

module d2cd_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [11:0] year_number,
  input wire logic [8:0]  day_in_year,
  input wire logic [3:0]  month_number,
  input wire logic [4:0]  day_in_month,
  input wire logic [2:0]  weekday
);

  // a stalled result keeps its fields
  `D2CD_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(year_number) && $stable(day_in_year) && $stable(month_number) && $stable(day_in_month) && $stable(weekday))

  // one item at a time: no input right after an input transfer
  `D2CD_ASSERT(a_busy_after_xfer, in_valid && in_ready |=> !in_ready)

  // month, weekday and year stay in their ranges
  `D2CD_ASSERT_VALID(a_ranges, month_number >= 4'd1 && month_number <= 4'd12 && weekday <= 3'd6 && year_number >= 12'd1980 && year_number <= 12'd2159)

  // the last day of a leap year is December 31
  `D2CD_ASSERT_VALID(a_year_end, day_in_year != 9'd366 || (month_number == 4'd12 && day_in_month == 5'd31))

endmodule

bind days_to_calendar_date d2cd_check u_d2cd_check (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (days.valid),
  .in_ready     (days.ready),
  .out_valid    (date.valid),
  .out_ready    (date.ready),
  .year_number  (date.year_number),
  .day_in_year  (date.day_in_year),
  .month_number (date.month_number),
  .day_in_month (date.day_in_month),
  .weekday      (date.weekday)
);

`default_nettype wire
